// ===== sv/vic_pkg.sv =====
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and constants of the velocity integrator with clamp and drag.
// ----------------------------------------------------------------------------
package vic_pkg;

	localparam int VecW = 32;
	localparam int MaxSpeedW = 31;
	localparam int DragW = 16;
	localparam int DtW = 16;
	localparam int FuncW = 3;
	localparam int CfgDataW = 32;
	localparam int IterW = 5;

	localparam logic [MaxSpeedW-1:0] MaxSpeedRst = '1;
	localparam logic [DragW-1:0] DragRst = '0;

	localparam logic [FuncW-1:0] FUNC_TICK = 3'd0;
	localparam logic [FuncW-1:0] FUNC_ADD = 3'd1;
	localparam logic [FuncW-1:0] FUNC_STOP = 3'd2;
	localparam logic [FuncW-1:0] FUNC_FREEZE = 3'd3;
	localparam logic [FuncW-1:0] FUNC_RESUME = 3'd4;

	localparam logic CFG_MAX_SPEED = 1'b0;
	localparam logic CFG_DRAG = 1'b1;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_DEC  = 14'b00000000000010,
		ST_SQ   = 14'b00000000000100,
		ST_SUM  = 14'b00000000001000,
		ST_CMP  = 14'b00000000010000,
		ST_SQRT = 14'b00000000100000,
		ST_MULC = 14'b00000001000000,
		ST_DIVI = 14'b00000010000000,
		ST_DIV  = 14'b00000100000000,
		ST_WRC  = 14'b00001000000000,
		ST_MOVE = 14'b00010000000000,
		ST_DRAG = 14'b00100000000000,
		ST_FIN  = 14'b01000000000000,
		ST_DONE = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic load;
		logic dec;
		logic sq;
		logic sum;
		logic sqrt_init;
		logic sqrt_step;
		logic mulc;
		logic div_init;
		logic div_step;
		logic clamp_wr;
		logic move;
		logic drag;
		logic fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic tick_go;
		logic clamp;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/vic_ctrl.sv =====
// ----------------------------------------------------------------------------
// vic_ctrl
// Sequencer: steps the datapath through decode, clamp, move and drag.
// ----------------------------------------------------------------------------
module vic_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  vic_pkg::sts_t   sts,
	output vic_pkg::cmd_t   cmd
);

	vic_pkg::state_t state_q, state_d;
	logic [vic_pkg::IterW-1:0] cnt_q, cnt_d;
	logic last;

	assign last = (cnt_q == '0);
	assign in_stall = (state_q != vic_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		case (state_q)
			vic_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = vic_pkg::ST_DEC;
				end
			end
			vic_pkg::ST_DEC: begin
				cmd.dec = 1'b1;
				state_d = sts.tick_go ? vic_pkg::ST_SQ : vic_pkg::ST_DONE;
			end
			vic_pkg::ST_SQ: begin
				cmd.sq = 1'b1;
				state_d = vic_pkg::ST_SUM;
			end
			vic_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = vic_pkg::ST_CMP;
			end
			vic_pkg::ST_CMP: begin
				cmd.sqrt_init = 1'b1;
				cnt_d = '1;
				state_d = sts.clamp ? vic_pkg::ST_SQRT : vic_pkg::ST_MOVE;
			end
			vic_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (last) state_d = vic_pkg::ST_MULC;
			end
			vic_pkg::ST_MULC: begin
				cmd.mulc = 1'b1;
				state_d = vic_pkg::ST_DIVI;
			end
			vic_pkg::ST_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d = '1;
				state_d = vic_pkg::ST_DIV;
			end
			vic_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (last) state_d = vic_pkg::ST_WRC;
			end
			vic_pkg::ST_WRC: begin
				cmd.clamp_wr = 1'b1;
				state_d = vic_pkg::ST_MOVE;
			end
			vic_pkg::ST_MOVE: begin
				cmd.move = 1'b1;
				state_d = vic_pkg::ST_DRAG;
			end
			vic_pkg::ST_DRAG: begin
				cmd.drag = 1'b1;
				state_d = vic_pkg::ST_FIN;
			end
			vic_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = vic_pkg::ST_DONE;
			end
			vic_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = vic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vic_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vic_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== sv/vic_dp.sv =====
// ----------------------------------------------------------------------------
// vic_dp
// Datapath: velocity state, two multiplier lanes, square root and dividers.
// ----------------------------------------------------------------------------
module vic_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vic_pkg::cmd_t                  cmd,
	output vic_pkg::sts_t                  sts,
	input  logic                           cfg_valid,
	input  logic                           cfg_index,
	input  logic [vic_pkg::CfgDataW-1:0]   cfg_data,
	input  logic [vic_pkg::FuncW-1:0]      func,
	input  logic [vic_pkg::DtW-1:0]        delta_time,
	input  logic signed [vic_pkg::VecW-1:0] add_x,
	input  logic signed [vic_pkg::VecW-1:0] add_y,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic signed [vic_pkg::VecW-1:0] move_x,
	output logic signed [vic_pkg::VecW-1:0] move_y,
	output logic signed [vic_pkg::VecW-1:0] vel_x,
	output logic signed [vic_pkg::VecW-1:0] vel_y,
	output logic signed [vic_pkg::VecW-1:0] recent_x,
	output logic signed [vic_pkg::VecW-1:0] recent_y,
	output logic                           is_frozen
);

	localparam int W = vic_pkg::VecW;

	logic [vic_pkg::MaxSpeedW-1:0] max_speed_q;
	logic [vic_pkg::DragW-1:0] drag_q;
	logic [vic_pkg::FuncW-1:0] func_q;
	logic [vic_pkg::DtW-1:0] dt_q;
	logic signed [W-1:0] ax_q, ay_q;

	logic signed [W-1:0] vx_q, vy_q, ix_q, iy_q, mx_q, my_q;
	logic frz_q;
	logic out_valid_q;

	logic [2*W-1:0] px_q, py_q, m2_q, xs_q;
	logic [W+2:0] rem_q;
	logic [W-1:0] root_q;
	logic [W-1:0] rx_q, ry_q, nx_q, ny_q, qx_q, qy_q;

	logic [W-1:0] ux, uy;
	logic signed [W:0] sumx, sumy;
	logic signed [W-1:0] satx, saty;
	logic [W+2:0] remsh, trial;
	logic [W:0] tx, ty;
	logic [W-1:0] hx, hy;

	assign ux = vx_q[W-1] ? W'(-vx_q) : W'(vx_q);
	assign uy = vy_q[W-1] ? W'(-vy_q) : W'(vy_q);

	assign sumx = (W+1)'(vx_q) + (W+1)'(ax_q);
	assign sumy = (W+1)'(vy_q) + (W+1)'(ay_q);
	assign satx = (sumx[W] != sumx[W-1]) ? {sumx[W], {(W-1){~sumx[W]}}} : sumx[W-1:0];
	assign saty = (sumy[W] != sumy[W-1]) ? {sumy[W], {(W-1){~sumy[W]}}} : sumy[W-1:0];

	// one result bit per step of the digit-by-digit root, taking two radicand bits
	assign remsh = {rem_q[W:0], xs_q[2*W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	assign tx = {rx_q, nx_q[W-1]};
	assign ty = {ry_q, ny_q[W-1]};

	assign hx = px_q[W+15:16];
	assign hy = py_q[W+15:16];

	assign sts.tick_go = (func_q == vic_pkg::FUNC_TICK) && !frz_q;
	assign sts.clamp = (m2_q >= px_q) && (m2_q != '0);
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= vic_pkg::MaxSpeedRst;
			drag_q <= vic_pkg::DragRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				vic_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data[vic_pkg::MaxSpeedW-1:0];
				vic_pkg::CFG_DRAG: drag_q <= cfg_data[vic_pkg::DragW-1:0];
				default: ;
			endcase
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= '0;
			vy_q <= '0;
			ix_q <= '0;
			iy_q <= '0;
			frz_q <= 1'b0;
		end else if (cmd.dec) begin
			case (func_q)
				vic_pkg::FUNC_ADD: begin
					if (!frz_q) begin
						vx_q <= satx;
						vy_q <= saty;
						ix_q <= ax_q;
						iy_q <= ay_q;
					end
				end
				vic_pkg::FUNC_STOP: begin
					vx_q <= '0;
					vy_q <= '0;
				end
				vic_pkg::FUNC_FREEZE: frz_q <= 1'b1;
				vic_pkg::FUNC_RESUME: frz_q <= 1'b0;
				default: ;
			endcase
		end else if (cmd.clamp_wr) begin
			vx_q <= vx_q[W-1] ? W'(-qx_q) : W'(qx_q);
			vy_q <= vy_q[W-1] ? W'(-qy_q) : W'(qy_q);
		end else if (cmd.fin) begin
			vx_q <= vx_q[W-1] ? vx_q + W'(hx) : vx_q - W'(hx);
			vy_q <= vy_q[W-1] ? vy_q + W'(hy) : vy_q - W'(hy);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			dt_q <= delta_time;
			ax_q <= add_x;
			ay_q <= add_y;
		end
		if (cmd.dec) begin
			mx_q <= '0;
			my_q <= '0;
		end else if (cmd.drag) begin
			mx_q <= vx_q[W-1] ? W'(-hx) : W'(hx);
			my_q <= vy_q[W-1] ? W'(-hy) : W'(hy);
		end
		// one multiplier per lane, operands picked by step
		if (cmd.sq) begin
			px_q <= ux * ux;
			py_q <= uy * uy;
		end else if (cmd.sum) begin
			m2_q <= px_q + py_q;
			px_q <= (2*W)'(max_speed_q * max_speed_q);
		end else if (cmd.mulc) begin
			px_q <= (2*W)'(ux * max_speed_q);
			py_q <= (2*W)'(uy * max_speed_q);
		end else if (cmd.move) begin
			px_q <= (2*W)'(ux * dt_q);
			py_q <= (2*W)'(uy * dt_q);
		end else if (cmd.drag) begin
			px_q <= (2*W)'(ux * drag_q);
			py_q <= (2*W)'(uy * drag_q);
		end
		if (cmd.sqrt_init) begin
			xs_q <= m2_q;
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			xs_q <= {xs_q[2*W-3:0], 2'b00};
			if (remsh >= trial) begin
				rem_q <= remsh - trial;
				root_q <= {root_q[W-2:0], 1'b1};
			end else begin
				rem_q <= remsh;
				root_q <= {root_q[W-2:0], 1'b0};
			end
		end
		// quotient fits in 32 bits since the high half stays below the root
		if (cmd.div_init) begin
			rx_q <= px_q[2*W-1:W];
			ry_q <= py_q[2*W-1:W];
			nx_q <= px_q[W-1:0];
			ny_q <= py_q[W-1:0];
			qx_q <= '0;
			qy_q <= '0;
		end else if (cmd.div_step) begin
			nx_q <= {nx_q[W-2:0], 1'b0};
			ny_q <= {ny_q[W-2:0], 1'b0};
			if (tx >= {1'b0, root_q}) begin
				rx_q <= W'(tx - {1'b0, root_q});
				qx_q <= {qx_q[W-2:0], 1'b1};
			end else begin
				rx_q <= tx[W-1:0];
				qx_q <= {qx_q[W-2:0], 1'b0};
			end
			if (ty >= {1'b0, root_q}) begin
				ry_q <= W'(ty - {1'b0, root_q});
				qy_q <= {qy_q[W-2:0], 1'b1};
			end else begin
				ry_q <= ty[W-1:0];
				qy_q <= {qy_q[W-2:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			move_x <= mx_q;
			move_y <= my_q;
			vel_x <= vx_q;
			vel_y <= vy_q;
			recent_x <= ix_q;
			recent_y <= iy_q;
			is_frozen <= frz_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/velocity_integrator_clamp_drag_top.sv =====
// ----------------------------------------------------------------------------
// velocity_integrator_clamp_drag_top
// 2D velocity integrator with speed clamp and drag, one result per request.
// ----------------------------------------------------------------------------
// non-tick requests and frozen ticks go from decode straight to the result; a tick
// without clamp skips the 32-step root and the 32-step divide that a clamped tick runs
// throughput: one request at a time, next request taken the cycle after the
// result is loaded into the output register
// reset: asynchronous, clears velocity, impulse, frozen flag and restores config
module velocity_integrator_clamp_drag_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [vic_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [vic_pkg::FuncW-1:0]       func,
	input  logic [vic_pkg::DtW-1:0]         delta_time,
	input  logic signed [vic_pkg::VecW-1:0] add_x,
	input  logic signed [vic_pkg::VecW-1:0] add_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [vic_pkg::VecW-1:0] move_x,
	output logic signed [vic_pkg::VecW-1:0] move_y,
	output logic signed [vic_pkg::VecW-1:0] vel_x,
	output logic signed [vic_pkg::VecW-1:0] vel_y,
	output logic signed [vic_pkg::VecW-1:0] recent_x,
	output logic signed [vic_pkg::VecW-1:0] recent_y,
	output logic                            is_frozen
);

	vic_pkg::cmd_t cmd;
	vic_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	vic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vic_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.delta_time (delta_time),
		.add_x      (add_x),
		.add_y      (add_y),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.move_x     (move_x),
		.move_y     (move_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.recent_x   (recent_x),
		.recent_y   (recent_y),
		.is_frozen  (is_frozen)
	);

endmodule

// ===== sv/vic_checker.sv =====
// ----------------------------------------------------------------------------
// vic_checker
// Port-level checks of the velocity integrator, bound to the top level.
// ----------------------------------------------------------------------------
module vic_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_ready,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// a taken request keeps the input closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind velocity_integrator_clamp_drag_top vic_checker u_vic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

// ===== bench/tb_velocity_integrator_clamp_drag_top.sv =====
// ----------------------------------------------------------------------------
// tb_velocity_integrator_clamp_drag_top
// Self-checking bench for the velocity integrator with speed clamp and drag.
// A directed table covers reset state, saturation, freeze and unused codes.
// Random phases follow under several register settings. Each result is
// compared field by field against its table entry or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_velocity_integrator_clamp_drag_top;

	typedef struct packed {
		logic signed [vic_pkg::VecW-1:0] mx;
		logic signed [vic_pkg::VecW-1:0] my;
		logic signed [vic_pkg::VecW-1:0] vx;
		logic signed [vic_pkg::VecW-1:0] vy;
		logic signed [vic_pkg::VecW-1:0] rx;
		logic signed [vic_pkg::VecW-1:0] ry;
		logic                            fz;
	} motion_t;

	typedef struct {
		logic [vic_pkg::FuncW-1:0]       fn;
		logic [vic_pkg::DtW-1:0]         dt;
		logic signed [vic_pkg::VecW-1:0] ax;
		logic signed [vic_pkg::VecW-1:0] ay;
		bit                              typed;
		motion_t                         res;
	} row_t;

	localparam int IdleLimit = 5000;
	localparam logic signed [vic_pkg::VecW-1:0] VMAX = 32'sh7fffffff;
	localparam logic signed [vic_pkg::VecW-1:0] VMIN = 32'sh80000000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [vic_pkg::CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [vic_pkg::FuncW-1:0] func;
	logic [vic_pkg::DtW-1:0] delta_time;
	logic signed [vic_pkg::VecW-1:0] add_x;
	logic signed [vic_pkg::VecW-1:0] add_y;
	logic out_valid;
	logic out_stall;
	logic signed [vic_pkg::VecW-1:0] move_x;
	logic signed [vic_pkg::VecW-1:0] move_y;
	logic signed [vic_pkg::VecW-1:0] vel_x;
	logic signed [vic_pkg::VecW-1:0] vel_y;
	logic signed [vic_pkg::VecW-1:0] recent_x;
	logic signed [vic_pkg::VecW-1:0] recent_y;
	logic is_frozen;

	velocity_integrator_clamp_drag_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .delta_time(delta_time),
		.add_x(add_x), .add_y(add_y),
		.out_valid(out_valid), .out_stall(out_stall), .move_x(move_x), .move_y(move_y),
		.vel_x(vel_x), .vel_y(vel_y), .recent_x(recent_x), .recent_y(recent_y),
		.is_frozen(is_frozen)
	);

	// model state
	longint speed_x, speed_y, kick_x, kick_y;
	bit frozen;
	longint unsigned speed_lim, drag_frac;

	motion_t motion_q[$];
	row_t rows[$];
	int errors, n_items, n_results, n_clamps, n_cfg;
	int stall_mode, stall_cnt, burst_left;
	bit stall_lvl, no_gaps;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint scale_mag(longint v, longint unsigned num, longint unsigned den);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		m = (m * num) / den;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic advance_motion(input logic [vic_pkg::FuncW-1:0] fn,
			input logic [vic_pkg::DtW-1:0] dt,
			input logic signed [vic_pkg::VecW-1:0] ax,
			input logic signed [vic_pkg::VecW-1:0] ay,
			output motion_t r);
		longint mx, my;
		longint unsigned ux, uy, m2;
		mx = 0;
		my = 0;
		case (fn)
			vic_pkg::FUNC_TICK: begin
				if (!frozen) begin
					ux = (speed_x < 0) ? -speed_x : speed_x;
					uy = (speed_y < 0) ? -speed_y : speed_y;
					m2 = ux * ux + uy * uy;
					if (m2 >= speed_lim * speed_lim && m2 != 0) begin
						n_clamps++;
						ux = root64(m2);
						speed_x = scale_mag(speed_x, speed_lim, ux);
						speed_y = scale_mag(speed_y, speed_lim, ux);
					end
					mx = scale_mag(speed_x, dt, 65536);
					my = scale_mag(speed_y, dt, 65536);
					speed_x -= scale_mag(speed_x, drag_frac, 65536);
					speed_y -= scale_mag(speed_y, drag_frac, 65536);
				end
			end
			vic_pkg::FUNC_ADD: begin
				if (!frozen) begin
					speed_x = sat32(speed_x + longint'(ax));
					speed_y = sat32(speed_y + longint'(ay));
					kick_x = ax;
					kick_y = ay;
				end
			end
			vic_pkg::FUNC_STOP: begin
				speed_x = 0;
				speed_y = 0;
			end
			vic_pkg::FUNC_FREEZE: frozen = 1'b1;
			vic_pkg::FUNC_RESUME: frozen = 1'b0;
			default: ;
		endcase
		r.mx = mx[31:0];
		r.my = my[31:0];
		r.vx = speed_x[31:0];
		r.vy = speed_y[31:0];
		r.rx = kick_x[31:0];
		r.ry = kick_y[31:0];
		r.fz = frozen;
	endtask

	task automatic report_mismatch(input string field, input logic [vic_pkg::VecW-1:0] got,
			input logic [vic_pkg::VecW-1:0] want);
		errors++;
		$display("mismatch result %0d %s: got %h expected %h", n_results, field, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		motion_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (motion_q.size() == 0) begin
				errors++;
				$display("unexpected result %0d", n_results);
			end else begin
				e = motion_q.pop_front();
				if (move_x !== e.mx) report_mismatch("move_x", move_x, e.mx);
				if (move_y !== e.my) report_mismatch("move_y", move_y, e.my);
				if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
				if (recent_x !== e.rx) report_mismatch("recent_x", recent_x, e.rx);
				if (recent_y !== e.ry) report_mismatch("recent_y", recent_y, e.ry);
				if (is_frozen !== e.fz)
					report_mismatch("is_frozen", vic_pkg::VecW'(is_frozen),
						vic_pkg::VecW'(e.fz));
			end
			n_results++;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			default: begin
				if (stall_cnt == 0) begin
					stall_lvl = $urandom_range(0, 1);
					stall_cnt = $urandom_range(1, 20);
				end
				stall_cnt--;
				out_stall <= stall_lvl;
			end
		endcase
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout: no progress for %0d cycles", IdleLimit);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input row_t r);
		motion_t m;
		@(negedge clk);
		if (burst_left == 0 && !no_gaps) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		func <= r.fn;
		delta_time <= r.dt;
		add_x <= r.ax;
		add_y <= r.ay;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		advance_motion(r.fn, r.dt, r.ax, r.ay, m);
		motion_q.push_back(r.typed ? r.res : m);
		n_items++;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (motion_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [vic_pkg::CfgDataW-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == vic_pkg::CFG_MAX_SPEED)
			speed_lim = data[vic_pkg::MaxSpeedW-1:0];
		else
			drag_frac = data[vic_pkg::DragW-1:0];
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input logic [vic_pkg::FuncW-1:0] fn,
			input logic [vic_pkg::DtW-1:0] dt,
			input logic signed [vic_pkg::VecW-1:0] ax,
			input logic signed [vic_pkg::VecW-1:0] ay,
			input bit typed, input motion_t res);
		row_t r;
		r.fn = fn;
		r.dt = dt;
		r.ax = ax;
		r.ay = ay;
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endtask

	function automatic logic signed [vic_pkg::VecW-1:0] rand_vec;
		logic [vic_pkg::VecW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = VMAX;
			1: v = VMIN;
			2: v = '0;
			3: v = $urandom;
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic row_t rand_row;
		row_t r;
		int p;
		p = $urandom_range(0, 99);
		r.typed = 0;
		r.res = '0;
		r.fn = (p < 40) ? vic_pkg::FUNC_TICK : (p < 75) ? vic_pkg::FUNC_ADD :
			(p < 80) ? vic_pkg::FUNC_STOP : (p < 87) ? vic_pkg::FUNC_FREEZE :
			(p < 95) ? vic_pkg::FUNC_RESUME : 3'($urandom_range(5, 7));
		case ($urandom_range(0, 5))
			0: r.dt = '0;
			1: r.dt = '1;
			default: r.dt = vic_pkg::DtW'($urandom);
		endcase
		r.ax = rand_vec();
		r.ay = rand_vec();
		return r;
	endfunction

	initial begin
		motion_t z, t;
		row_t r;
		logic [vic_pkg::CfgDataW-1:0] lim_val, drag_val;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_clamps = 0;
		n_cfg = 0;
		stall_mode = 0;
		stall_cnt = 0;
		stall_lvl = 0;
		burst_left = 0;
		no_gaps = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = vic_pkg::CFG_MAX_SPEED;
		cfg_data = '0;
		in_valid = 1'b0;
		func = vic_pkg::FUNC_TICK;
		delta_time = '0;
		add_x = '0;
		add_y = '0;
		out_stall = 1'b0;
		speed_x = 0;
		speed_y = 0;
		kick_x = 0;
		kick_y = 0;
		frozen = 0;
		speed_lim = vic_pkg::MaxSpeedRst;
		drag_frac = vic_pkg::DragRst;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, default registers
		z = '0;
		add_row(vic_pkg::FUNC_STOP, '1, VMAX, VMIN, 1, z);
		t = z;
		t.vx = VMAX; t.vy = VMIN; t.rx = VMAX; t.ry = VMIN;
		add_row(vic_pkg::FUNC_ADD, '0, VMAX, VMIN, 1, t);
		add_row(vic_pkg::FUNC_ADD, '1, VMAX, VMIN, 1, t);   // saturates both ways
		t.fz = 1'b1;
		add_row(vic_pkg::FUNC_FREEZE, '0, '0, '0, 1, t);
		add_row(vic_pkg::FUNC_ADD, '0, 32'sd1, 32'sd1, 1, t);  // ignored while frozen
		add_row(vic_pkg::FUNC_TICK, '1, '0, '0, 1, t);          // frozen tick
		t.vx = '0; t.vy = '0;
		add_row(vic_pkg::FUNC_STOP, '0, '0, '0, 1, t);          // stop while frozen
		t.fz = 1'b0;
		add_row(vic_pkg::FUNC_RESUME, '1, '0, '0, 1, t);
		add_row(3'd5, '1, VMAX, VMAX, 1, t);
		add_row(3'd6, '0, VMIN, VMIN, 1, t);
		add_row(3'd7, '1, '1, '1, 1, t);
		add_row(vic_pkg::FUNC_TICK, '1, '0, '0, 1, t);          // zero vector stays zero
		add_row(vic_pkg::FUNC_ADD, '0, VMAX, VMAX, 0, z);
		add_row(vic_pkg::FUNC_TICK, '1, '0, '0, 0, z);          // clamps at the top limit
		add_row(vic_pkg::FUNC_TICK, '0, '0, '0, 0, z);
		add_row(vic_pkg::FUNC_ADD, '0, VMIN, 32'sh00012345, 0, z);
		add_row(vic_pkg::FUNC_TICK, 16'h8000, '0, '0, 0, z);
		add_row(vic_pkg::FUNC_ADD, '0, -32'sh00058000, 32'sh00030000, 0, z);
		add_row(vic_pkg::FUNC_TICK, 16'h0001, '0, '0, 0, z);
		foreach (rows[i])
			send_item(rows[i]);
		drain();

		// register phases, extremes first
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin lim_val = '0; drag_val = '0; end
				1: begin lim_val = 32'hffffffff; drag_val = 32'h0000ffff; end
				2: begin lim_val = 32'h80000001; drag_val = 32'hffff0000; end
				3: begin lim_val = 32'd1; drag_val = 32'd1; end
				default: begin
					lim_val = $urandom >> $urandom_range(0, 12);
					drag_val = $urandom >> $urandom_range(0, 16);
				end
			endcase
			cfg_write(vic_pkg::CFG_MAX_SPEED, lim_val);
			cfg_write(vic_pkg::CFG_DRAG, drag_val);
			stall_mode = ph % 3;
			no_gaps = (ph % 4 == 1);
			if (ph == 0) begin
				// zero limit: a moving vector clamps to zero, zero vector stays zero
				r = rand_row();
				r.fn = vic_pkg::FUNC_RESUME;
				send_item(r);
				r.fn = vic_pkg::FUNC_ADD;
				r.ax = 32'sh00100000;
				send_item(r);
				r.fn = vic_pkg::FUNC_TICK;
				send_item(r);
				r.fn = vic_pkg::FUNC_STOP;
				send_item(r);
				r.fn = vic_pkg::FUNC_TICK;
				send_item(r);
			end
			for (int k = 0; k < 90; k++) begin
				if (k == 45 && ph == 5) begin
					// hold off until every pending result is back
					@(negedge clk);
					in_valid <= 1'b0;
					while (motion_q.size() != 0)
						@(posedge clk);
				end
				send_item(rand_row());
			end
			drain();
		end

		$display("covered %0d requests, %0d results, %0d clamped ticks, %0d register writes",
			n_items, n_results, n_clamps, n_cfg);
		$display("%0d mismatches across 10 register settings", errors);
		if (errors == 0 && motion_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
